// ===== rtl/fsmp_pkg.sv =====
// Shared types, opcodes and word helpers for the five-stage MIPS subset pipeline.
package fsmp_pkg;

   // transaction action codes
   localparam logic [2:0] ACT_LOAD_INSTR = 3'd0;
   localparam logic [2:0] ACT_LOAD_DATA  = 3'd1;
   localparam logic [2:0] ACT_TICK       = 3'd2;
   localparam logic [2:0] ACT_READ_REG   = 3'd3;
   localparam logic [2:0] ACT_READ_WORD  = 3'd4;

   // opcode and function fields
   localparam logic [5:0] OP_RTYPE   = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;
   localparam logic [5:0] FUNCT_ADDU = 6'd33;
   localparam logic [3:0] OP_BRANCH_HI = 4'b0001;

   localparam logic [31:0] HALT_WORD = 32'hffff_ffff;
   localparam int STORE_ADDR_W = 10;

   typedef struct packed {
      logic [15:0] imm;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  wreg;
      logic        is_i;
      logic        rd;
      logic        wr;
      logic        add;
      logic        we;
   } ex_ctl_type;

   typedef struct packed {
      logic [4:0] rt;
      logic [4:0] wreg;
      logic       rd;
      logic       wr;
      logic       we;
   } mem_ctl_type;

   typedef struct packed {
      logic [4:0] wreg;
      logic       we;
   } wb_ctl_type;

   // which byte of the word (0 = most significant) a bank holds for a given start
   function automatic logic [1:0] bank_offset(input logic [1:0] bank, input logic [1:0] lo);
      return 2'(bank - lo);
   endfunction

   // big-endian word from the four bank outputs, starting at bank lo
   function automatic logic [31:0] word_assemble(input logic [3:0][7:0] q,
                                                 input logic [1:0] lo);
      logic [31:0] w;
      w = '0;
      for (int k = 0; k < 4; k++) begin
         w[31 - 8*k -: 8] = q[2'(lo + 2'(k))];
      end
      return w;
   endfunction

endpackage

// ===== rtl/five_stage_mips_subset_pipeline.sv =====
// Five-stage MIPS subset pipeline (addu, subu, lw, sw, bne) with host load and read access.
//
// One transaction is taken per clock when the input is not stalled: loads of instruction
// or data bytes, reads of a register or a data word, and clock ticks that advance fetch,
// decode, execute, memory and writeback by one step each. Every transaction returns one
// result, registered, in the cycle after it is taken; while that result is held off by
// rsp_stall the input is stalled, and a new transaction is taken in the same cycle the
// previous result leaves, so transactions run back to back when the receiver does not
// stall. Instruction and data memories are four byte-wide banks each, so an unaligned
// big-endian word is read or written in one access; the fetched word and a load's data
// land in the bank read registers and are decoded from there. After reset a clearing
// pass zeroes both memories, one row of four bytes per cycle; no transaction is taken
// during it. MEM_BYTES must be a power of two.
module five_stage_mips_subset_pipeline #(
   parameter int MEM_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [9:0]  req_address,
   input  logic [7:0]  req_byte_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_done_res,
   output logic [31:0] rsp_fetch_address,
   output logic        rsp_reg_write_valid,
   output logic [4:0]  rsp_reg_write_index,
   output logic [31:0] rsp_reg_write_value,
   output logic        rsp_store_valid,
   output logic [fsmp_pkg::STORE_ADDR_W-1:0] rsp_store_address,
   output logic [31:0] rsp_store_value,
   output logic [31:0] rsp_read_value
);
   import fsmp_pkg::*;

   localparam int AW    = $clog2(MEM_BYTES);
   localparam int DEPTH = MEM_BYTES / 4;
   localparam int RW    = AW - 2;

   // row of bank "bank" that holds a byte of the word starting at base
   function automatic logic [RW-1:0] bank_row(input logic [AW-1:0] base,
                                              input logic [1:0] bank);
      logic [AW-1:0] b;
      b = base + AW'(bank_offset(bank, base[1:0]));
      return b[AW-1:2];
   endfunction

   // clearing pass
   logic          clr_busy_ff;
   logic [RW-1:0] clr_row_ff;

   // front end
   logic        fidle_ff, didle_ff, fetched_ff;
   logic [31:0] pc_ff;
   logic [1:0]  flo_ff;
   logic [3:0][7:0] ibank_q_ff;

   // execute, memory, writeback latches
   logic        ex_idle_ff, mem_idle_ff, wb_idle_ff;
   logic [31:0] ex_a_ff, ex_b_ff;
   ex_ctl_type  ex_ctl_ff;
   logic [31:0] mem_alu_ff, mem_sd_ff;
   mem_ctl_type mem_ctl_ff;
   logic [31:0] wb_alu_ff;
   logic        wb_ld_ff;
   logic [1:0]  wlo_ff;
   wb_ctl_type  wb_ctl_ff;
   logic [3:0][7:0] dbank_qa_ff;
   logic [3:0][7:0] dbank_qb_ff;

   logic [31:0] rf_ff [32];

   // result register
   logic        rsp_valid_ff;
   logic        rsp_rwv_ff;
   logic [4:0]  rsp_rwi_ff;
   logic [31:0] rsp_rwval_ff;
   logic        rsp_sv_ff;
   logic [STORE_ADDR_W-1:0] rsp_sa_ff;
   logic [31:0] rsp_sval_ff;
   logic [31:0] rsp_rdreg_ff;
   logic        rsp_dread_ff;
   logic [1:0]  hlo_ff;

   // effective pipeline view
   logic [31:0] dec_word, pc_now, wb_value;
   logic        halt_seen, f_idle, d_idle, all_idle;
   logic        accept, tick_go;

   assign dec_word  = word_assemble(ibank_q_ff, flo_ff);
   assign halt_seen = fetched_ff && (dec_word == HALT_WORD);
   assign f_idle    = fidle_ff || halt_seen;
   assign d_idle    = didle_ff || halt_seen;
   assign pc_now    = (fetched_ff && !halt_seen) ? pc_ff + 32'd4 : pc_ff;
   assign wb_value  = wb_ld_ff ? word_assemble(dbank_qa_ff, wlo_ff) : wb_alu_ff;
   assign all_idle  = f_idle && d_idle && ex_idle_ff && mem_idle_ff && wb_idle_ff;

   assign req_stall = clr_busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign tick_go   = accept && (req_action == ACT_TICK) && !all_idle;

   // stage logic for one tick
   logic        wb_fwd, mem_fwd;
   logic [31:0] st_data, op_a, op_b, ex_imm, alu;
   logic [5:0]  d_op, d_funct;
   logic [4:0]  d_rs, d_rt;
   logic        d_bne, d_ld, d_st;
   logic [31:0] rf_rs, rf_rt, d_imm;
   ex_ctl_type  dctl;
   logic        load_stall, take_branch;
   logic [31:0] fpc;

   always_comb begin
      wb_fwd  = !wb_idle_ff && wb_ctl_ff.we && (wb_ctl_ff.wreg != 5'd0);
      mem_fwd = !mem_idle_ff && mem_ctl_ff.we && (mem_ctl_ff.wreg != 5'd0);

      // store data forwarded from writeback
      st_data = (wb_fwd && (wb_ctl_ff.wreg == mem_ctl_ff.rt)) ? wb_value : mem_sd_ff;

      // execute operands, memory stage wins
      op_a = ex_a_ff;
      op_b = ex_b_ff;
      if (wb_fwd && (wb_ctl_ff.wreg == ex_ctl_ff.rs)) op_a = wb_value;
      if (wb_fwd && (wb_ctl_ff.wreg == ex_ctl_ff.rt)) op_b = wb_value;
      if (mem_fwd && (mem_ctl_ff.wreg == ex_ctl_ff.rs)) op_a = mem_alu_ff;
      if (mem_fwd && (mem_ctl_ff.wreg == ex_ctl_ff.rt)) op_b = mem_alu_ff;
      ex_imm = {{16{ex_ctl_ff.imm[15]}}, ex_ctl_ff.imm};
      if (ex_ctl_ff.is_i) begin
         alu = op_a + ex_imm;
      end else if (ex_ctl_ff.we) begin
         alu = ex_ctl_ff.add ? op_a + op_b : op_a - op_b;
      end else begin
         alu = '0;
      end

      // decode; register reads see this tick's writeback
      d_op    = dec_word[31:26];
      d_funct = dec_word[5:0];
      d_rs    = dec_word[25:21];
      d_rt    = dec_word[20:16];
      d_bne   = (d_op == OP_BNE);
      d_ld    = (d_op == OP_LW);
      d_st    = (d_op == OP_SW);
      rf_rs   = (wb_fwd && (wb_ctl_ff.wreg == d_rs)) ? wb_value : rf_ff[d_rs];
      rf_rt   = (wb_fwd && (wb_ctl_ff.wreg == d_rt)) ? wb_value : rf_ff[d_rt];
      d_imm   = {{16{dec_word[15]}}, dec_word[15:0]};

      dctl.imm  = dec_word[15:0];
      dctl.rs   = d_rs;
      dctl.rt   = d_rt;
      dctl.is_i = (d_op != OP_RTYPE) && (d_op[5:2] != OP_BRANCH_HI);
      dctl.wreg = dctl.is_i ? d_rt : dec_word[15:11];
      dctl.rd   = d_ld;
      dctl.wr   = d_st;
      dctl.add  = d_ld || d_st || (d_funct == FUNCT_ADDU) || (d_op == OP_BEQ);
      dctl.we   = !(d_st || d_bne || (d_op == OP_J));

      // load-use hazard on R-type and store consumers
      load_stall = !d_idle && !ex_idle_ff && ex_ctl_ff.is_i && ex_ctl_ff.rd &&
                   ((ex_ctl_ff.rt == d_rs) || (ex_ctl_ff.rt == d_rt)) &&
                   ((d_op == OP_RTYPE) || d_st);
      take_branch = !d_idle && d_bne && (rf_rs != rf_rt);
      fpc = take_branch ? pc_now + {d_imm[29:0], 2'b00} : pc_now;
   end

   // memory port controls
   logic       imem_re, dmem_rea, dmem_reb, dmem_st;
   logic [AW-1:0] host_addr;

   assign host_addr = AW'(32'(req_address));
   assign imem_re   = tick_go && !f_idle && !load_stall;
   assign dmem_st   = tick_go && !mem_idle_ff && mem_ctl_ff.wr;
   assign dmem_rea  = tick_go && !mem_idle_ff && !mem_ctl_ff.wr && mem_ctl_ff.rd;
   assign dmem_reb  = accept && (req_action == ACT_READ_WORD);

   // four byte banks per memory
   for (genvar j = 0; j < 4; j++) begin : g_bank
      logic [7:0]    imem [DEPTH];
      logic [7:0]    dmem [DEPTH];
      logic          iwe, dwe;
      logic [RW-1:0] iw_row, dw_row, ir_row, dra_row, drb_row;
      logic [7:0]    iw_data, dw_data;
      logic [1:0]    st_k;

      always_comb begin
         st_k    = bank_offset(2'(j), mem_alu_ff[1:0]);
         ir_row  = bank_row(fpc[AW-1:0], 2'(j));
         dra_row = bank_row(mem_alu_ff[AW-1:0], 2'(j));
         drb_row = bank_row(host_addr, 2'(j));
         // instruction bank write: clearing pass or host byte load
         iwe     = clr_busy_ff || (accept && (req_action == ACT_LOAD_INSTR) &&
                                   (host_addr[1:0] == 2'(j)));
         iw_row  = clr_busy_ff ? clr_row_ff : host_addr[AW-1:2];
         iw_data = clr_busy_ff ? 8'd0 : req_byte_value;
         // data bank write: clearing pass, host byte load or store word
         dwe     = clr_busy_ff || dmem_st ||
                   (accept && (req_action == ACT_LOAD_DATA) && (host_addr[1:0] == 2'(j)));
         if (clr_busy_ff) begin
            dw_row  = clr_row_ff;
            dw_data = 8'd0;
         end else if (dmem_st) begin
            dw_row  = dra_row;
            dw_data = 8'(st_data >> (5'd24 - {st_k, 3'b000}));
         end else begin
            dw_row  = host_addr[AW-1:2];
            dw_data = req_byte_value;
         end
      end

      always_ff @(posedge clock) begin
         if (iwe) imem[iw_row] <= iw_data;
         if (imem_re) ibank_q_ff[j] <= imem[ir_row];
      end

      always_ff @(posedge clock) begin
         if (dwe) dmem[dw_row] <= dw_data;
         if (dmem_rea) dbank_qa_ff[j] <= dmem[dra_row];
         if (dmem_reb) dbank_qb_ff[j] <= dmem[drb_row];
      end
   end

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == RW'(DEPTH - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // pipeline control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fidle_ff    <= 1'b0;
         didle_ff    <= 1'b1;
         fetched_ff  <= 1'b0;
         pc_ff       <= '0;
         ex_idle_ff  <= 1'b1;
         mem_idle_ff <= 1'b1;
         wb_idle_ff  <= 1'b1;
         for (int r = 0; r < 32; r++) rf_ff[r] <= '0;
      end else if (tick_go) begin
         if (wb_fwd) rf_ff[wb_ctl_ff.wreg] <= wb_value;
         wb_idle_ff  <= mem_idle_ff;
         mem_idle_ff <= ex_idle_ff;
         ex_idle_ff  <= d_idle || load_stall;
         if (!load_stall) begin
            if (!f_idle) begin
               pc_ff      <= fpc;
               fetched_ff <= 1'b1;
               fidle_ff   <= 1'b0;
               didle_ff   <= 1'b0;
            end else begin
               pc_ff      <= pc_now;
               fetched_ff <= 1'b0;
               fidle_ff   <= 1'b1;
               didle_ff   <= 1'b1;
            end
         end
      end
   end

   // pipeline payload latches
   always_ff @(posedge clock) begin
      if (tick_go) begin
         if (!mem_idle_ff) begin
            wb_alu_ff      <= mem_alu_ff;
            wb_ld_ff       <= mem_ctl_ff.rd && !mem_ctl_ff.wr;
            wlo_ff         <= mem_alu_ff[1:0];
            wb_ctl_ff.wreg <= mem_ctl_ff.wreg;
            wb_ctl_ff.we   <= mem_ctl_ff.we;
         end
         if (!ex_idle_ff) begin
            mem_alu_ff      <= alu;
            mem_sd_ff       <= op_b;
            mem_ctl_ff.rt   <= ex_ctl_ff.rt;
            mem_ctl_ff.wreg <= ex_ctl_ff.wreg;
            mem_ctl_ff.rd   <= ex_ctl_ff.rd;
            mem_ctl_ff.wr   <= ex_ctl_ff.wr;
            mem_ctl_ff.we   <= ex_ctl_ff.we;
         end
         if (!d_idle) begin
            ex_a_ff   <= rf_rs;
            ex_b_ff   <= rf_rt;
            ex_ctl_ff <= dctl;
         end
         if (imem_re) flo_ff <= fpc[1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_rwv_ff   <= tick_go && wb_fwd;
         rsp_rwi_ff   <= (tick_go && wb_fwd) ? wb_ctl_ff.wreg : 5'd0;
         rsp_rwval_ff <= (tick_go && wb_fwd) ? wb_value : 32'd0;
         rsp_sv_ff    <= dmem_st;
         rsp_sa_ff    <= dmem_st ? STORE_ADDR_W'(mem_alu_ff[AW-1:0]) : '0;
         rsp_sval_ff  <= dmem_st ? st_data : 32'd0;
         rsp_rdreg_ff <= (req_action == ACT_READ_REG) ? rf_ff[req_address[4:0]] : 32'd0;
         rsp_dread_ff <= (req_action == ACT_READ_WORD);
         hlo_ff       <= host_addr[1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_done_res        = all_idle;
   assign rsp_fetch_address   = pc_now;
   assign rsp_reg_write_valid = rsp_rwv_ff;
   assign rsp_reg_write_index = rsp_rwi_ff;
   assign rsp_reg_write_value = rsp_rwval_ff;
   assign rsp_store_valid     = rsp_sv_ff;
   assign rsp_store_address   = rsp_sa_ff;
   assign rsp_store_value     = rsp_sval_ff;
   assign rsp_read_value      = rsp_dread_ff ? word_assemble(dbank_qb_ff, hlo_ff)
                                             : rsp_rdreg_ff;

   // checks
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rwv_ff |-> rsp_rwi_ff != 5'd0)
      else $error("write to register zero reported");

   a_stall_needs_load: assert property (@(posedge clock) disable iff (reset)
      load_stall |-> !ex_idle_ff && ex_ctl_ff.rd && !d_idle)
      else $error("load-use stall without a load in execute");

   a_fetch_stays_idle: assert property (@(posedge clock) disable iff (reset)
      f_idle |=> f_idle)
      else $error("fetch restarted after halt");

endmodule

// ===== tb/five_stage_mips_subset_pipeline_tb.sv =====
// Testbench for the five-stage MIPS subset pipeline: random programs checked against a predictor.
`timescale 1ns / 100ps

module five_stage_mips_subset_pipeline_tb;
   import fsmp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int ITEM_TARGET = 450;

   // codes used only by the stimulus
   localparam logic [2:0] ACT_SPARE_A = 3'd5;
   localparam logic [2:0] ACT_SPARE_B = 3'd6;
   localparam logic [2:0] ACT_SPARE_C = 3'd7;
   localparam logic [5:0] OP_ADDI     = 6'd8;
   localparam logic [5:0] FUNCT_SUB   = 6'd34;
   localparam logic [5:0] FUNCT_SUBU  = 6'd35;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_TICK;
   logic [9:0]  req_address = '0;
   logic [7:0]  req_byte_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_done_res;
   logic [31:0] rsp_fetch_address;
   logic        rsp_reg_write_valid;
   logic [4:0]  rsp_reg_write_index;
   logic [31:0] rsp_reg_write_value;
   logic        rsp_store_valid;
   logic [STORE_ADDR_W-1:0] rsp_store_address;
   logic [31:0] rsp_store_value;
   logic [31:0] rsp_read_value;

   typedef struct {
      logic        done;
      logic [31:0] fetch_addr;
      logic        wr_valid;
      logic [4:0]  wr_index;
      logic [31:0] wr_value;
      logic        st_valid;
      logic [9:0]  st_addr;
      logic [31:0] st_value;
      logic [31:0] rd_value;
   } pipe_rsp_type;

   // Predicts every result of the pipeline and checks the returned ones in order
   class pipe_scoreboard;
      logic [7:0]  imem [1024];
      logic [7:0]  dmem [1024];
      logic [31:0] regs [32];
      logic [31:0] pc;
      logic        f_idle, d_idle, x_idle, m_idle, w_idle;
      logic [31:0] d_word;
      logic [31:0] x_a, x_b;
      logic [15:0] x_imm;
      logic [4:0]  x_rs, x_rt, x_wreg;
      logic        x_is_i, x_rd, x_wr, x_add, x_we;
      logic [31:0] m_alu, m_sd;
      logic [4:0]  m_rt, m_wreg;
      logic        m_rd, m_wr, m_we;
      logic [31:0] w_val;
      logic [4:0]  w_wreg;
      logic        w_we;
      pipe_rsp_type pending[$];
      int          errors, checked, ticks, stores, reg_writes;

      function new();
         foreach (imem[i]) imem[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         foreach (regs[i]) regs[i] = '0;
         pc = '0; f_idle = 0; d_idle = 1; x_idle = 1; m_idle = 1; w_idle = 1;
         d_word = '0; x_a = '0; x_b = '0; x_imm = '0; x_rs = '0; x_rt = '0; x_wreg = '0;
         x_is_i = 0; x_rd = 0; x_wr = 0; x_add = 1; x_we = 0;
         m_alu = '0; m_sd = '0; m_rt = '0; m_wreg = '0; m_rd = 0; m_wr = 0; m_we = 0;
         w_val = '0; w_wreg = '0; w_we = 0;
      endfunction

      function logic [31:0] word_at(bit from_data, logic [9:0] a);
         logic [31:0] v;
         logic [9:0]  ix;
         v = '0;
         for (int k = 0; k < 4; k++) begin
            ix = a + 10'(k);
            v = {v[23:0], from_data ? dmem[ix] : imem[ix]};
         end
         return v;
      endfunction

      function logic [31:0] sext(logic [15:0] x);
         return {{16{x[15]}}, x};
      endfunction

      function bit all_idle();
         return f_idle && d_idle && x_idle && m_idle && w_idle;
      endfunction

      // advance the predicted state by one transaction and queue its result
      function void note_input(logic [2:0] act, logic [9:0] adr, logic [7:0] bv);
         pipe_rsp_type r;
         logic wb_fwd, mem_fwd, stall, n_w_idle, n_m_idle, n_x_idle, n_d_idle, n_f_idle;
         logic [31:0] n_w_val, n_alu, n_sd, n_a, n_b, n_dw, n_pc, fpc, sd, a, b, w;
         logic [4:0]  n_w_wreg, n_m_rt, n_m_wreg, rs, rt;
         logic        n_w_we, n_m_rd, n_m_wr, n_m_we;
         logic [15:0] n_imm;
         logic [4:0]  n_x_rs, n_x_rt, n_x_wreg;
         logic        n_is_i, n_x_rd, n_x_wr, n_x_add, n_x_we, is_bne, is_ld, is_st;
         logic [5:0]  op;
         r = '{default: '0};
         if (act == ACT_LOAD_INSTR) imem[adr] = bv;
         else if (act == ACT_LOAD_DATA) dmem[adr] = bv;
         else if (act == ACT_READ_REG) r.rd_value = regs[adr[4:0]];
         else if (act == ACT_READ_WORD) r.rd_value = word_at(1, adr);
         else if (act == ACT_TICK && !all_idle()) begin
            ticks++;
            wb_fwd = !w_idle && w_we && w_wreg != 0;
            mem_fwd = !m_idle && m_we && m_wreg != 0;
            n_w_val = w_val; n_w_wreg = w_wreg; n_w_we = w_we;
            n_alu = m_alu; n_sd = m_sd; n_m_rt = m_rt; n_m_wreg = m_wreg;
            n_m_rd = m_rd; n_m_wr = m_wr; n_m_we = m_we;
            n_a = x_a; n_b = x_b; n_imm = x_imm; n_x_rs = x_rs; n_x_rt = x_rt;
            n_x_wreg = x_wreg; n_is_i = x_is_i; n_x_rd = x_rd; n_x_wr = x_wr;
            n_x_add = x_add; n_x_we = x_we;
            n_dw = d_word; n_pc = pc; fpc = pc; stall = 0;
            // writeback
            if (wb_fwd) begin
               regs[w_wreg] = w_val;
               r.wr_valid = 1; r.wr_index = w_wreg; r.wr_value = w_val;
            end
            // memory
            n_w_idle = m_idle;
            if (!m_idle) begin
               sd = m_sd;
               if (wb_fwd && w_wreg == m_rt) sd = w_val;
               n_w_val = m_alu;
               if (m_wr) begin
                  for (int k = 0; k < 4; k++) dmem[m_alu[9:0] + 10'(k)] = sd[31 - 8*k -: 8];
                  r.st_valid = 1; r.st_addr = m_alu[9:0]; r.st_value = sd;
               end else if (m_rd) begin
                  n_w_val = word_at(1, m_alu[9:0]);
               end
               n_w_wreg = m_wreg; n_w_we = m_we;
            end
            // execute with forwarding, memory latch wins over writeback
            n_m_idle = x_idle;
            if (!x_idle) begin
               a = x_a; b = x_b;
               if (wb_fwd) begin
                  if (w_wreg == x_rs) a = w_val;
                  if (w_wreg == x_rt) b = w_val;
               end
               if (mem_fwd) begin
                  if (m_wreg == x_rs) a = m_alu;
                  if (m_wreg == x_rt) b = m_alu;
               end
               if (x_is_i) n_alu = a + sext(x_imm);
               else if (x_we) n_alu = x_add ? a + b : a - b;
               else n_alu = '0;
               n_sd = b; n_m_rt = x_rt; n_m_wreg = x_wreg;
               n_m_rd = x_rd; n_m_wr = x_wr; n_m_we = x_we;
            end
            // decode, load-use hold and branch
            n_x_idle = d_idle;
            if (!d_idle) begin
               w = d_word; op = w[31:26]; rs = w[25:21]; rt = w[20:16];
               is_bne = op == OP_BNE; is_ld = op == OP_LW; is_st = op == OP_SW;
               n_is_i = op != OP_RTYPE && op[5:2] != OP_BRANCH_HI;
               n_x_rd = is_ld; n_x_wr = is_st;
               n_x_we = !(is_st || is_bne || op == OP_J);
               n_x_add = is_ld || is_st || w[5:0] == FUNCT_ADDU || op == OP_BEQ;
               n_x_rs = rs; n_x_rt = rt;
               n_x_wreg = n_is_i ? rt : w[15:11];
               n_imm = w[15:0];
               n_a = regs[rs]; n_b = regs[rt];
               if (!x_idle && x_is_i && x_rd && (x_rt == rs || x_rt == rt) &&
                   (op == OP_RTYPE || is_st)) begin
                  stall = 1; n_x_idle = 1;
               end
               if (is_bne && regs[rs] != regs[rt]) fpc = pc + (sext(w[15:0]) << 2);
            end
            // fetch
            n_d_idle = f_idle; n_f_idle = f_idle;
            if (!f_idle) begin
               w = word_at(0, fpc[9:0]);
               if (w == HALT_WORD) begin
                  n_f_idle = 1; n_d_idle = 1; n_pc = fpc;
               end else begin
                  n_pc = fpc + 32'd4;
               end
               n_dw = w;
            end
            if (stall) begin
               n_pc = pc; n_f_idle = f_idle; n_dw = d_word; n_d_idle = d_idle;
            end
            pc = n_pc; f_idle = n_f_idle; d_word = n_dw; d_idle = n_d_idle;
            x_a = n_a; x_b = n_b; x_imm = n_imm; x_rs = n_x_rs; x_rt = n_x_rt;
            x_wreg = n_x_wreg; x_is_i = n_is_i; x_rd = n_x_rd; x_wr = n_x_wr;
            x_add = n_x_add; x_we = n_x_we; x_idle = n_x_idle;
            m_alu = n_alu; m_sd = n_sd; m_rt = n_m_rt; m_wreg = n_m_wreg;
            m_rd = n_m_rd; m_wr = n_m_wr; m_we = n_m_we; m_idle = n_m_idle;
            w_val = n_w_val; w_wreg = n_w_wreg; w_we = n_w_we; w_idle = n_w_idle;
         end
         r.done = all_idle();
         r.fetch_addr = pc;
         pending.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task cmp(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %h expected %h (result %0d)", name, got, want, checked));
      endtask

      task check(pipe_rsp_type got);
         pipe_rsp_type e;
         if (pending.size() == 0) begin
            report("result with no transaction outstanding");
            return;
         end
         e = pending.pop_front();
         cmp("done", 32'(got.done), 32'(e.done));
         cmp("fetch_address", got.fetch_addr, e.fetch_addr);
         cmp("reg_write_valid", 32'(got.wr_valid), 32'(e.wr_valid));
         cmp("reg_write_index", 32'(got.wr_index), 32'(e.wr_index));
         cmp("reg_write_value", got.wr_value, e.wr_value);
         cmp("store_valid", 32'(got.st_valid), 32'(e.st_valid));
         cmp("store_address", 32'(got.st_addr), 32'(e.st_addr));
         cmp("store_value", got.st_value, e.st_value);
         cmp("read_value", got.rd_value, e.rd_value);
         if (e.st_valid) stores++;
         if (e.wr_valid) reg_writes++;
         checked++;
      endtask
   endclass

   pipe_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 0;
   int sent = 0;

   five_stage_mips_subset_pipeline i_dut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stall pattern, with one long hold-off to back the pipeline up
   int stall_mode = 0, mode_left = 0, hold_left = 0;
   bit held = 0;
   always @(posedge clock) begin
      if (!held && sent > 120) begin
         held = 1;
         hold_left = 90;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      pipe_rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.done = rsp_done_res;
         got.fetch_addr = rsp_fetch_address;
         got.wr_valid = rsp_reg_write_valid;
         got.wr_index = rsp_reg_write_index;
         got.wr_value = rsp_reg_write_value;
         got.st_valid = rsp_store_valid;
         got.st_addr = rsp_store_address;
         got.st_value = rsp_store_value;
         got.rd_value = rsp_read_value;
         sb.check(got);
      end
   end

   // one transaction, sent in bursts with random gaps
   task automatic send(logic [2:0] act, logic [9:0] adr, logic [7:0] bv);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_address <= adr;
      req_byte_value <= bv;
      do @(posedge clock); while (req_stall);
      sb.note_input(act, adr, bv);
      burst_left--;
      sent++;
   endtask

   task automatic put_instr(logic [9:0] adr, logic [31:0] w);
      for (int k = 0; k < 4; k++) send(ACT_LOAD_INSTR, adr + 10'(k), w[31 - 8*k -: 8]);
   endtask

   function automatic logic [31:0] enc_r(logic [4:0] rs, rt, rd, logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
   endfunction

   // random instruction from the subset, plus the odd unusual opcode
   function automatic logic [31:0] rand_instr();
      logic [5:0] op;
      case ($urandom_range(0, 11))
         0, 1: return enc_i(OP_ADDI, pick_reg(), pick_reg(), 16'($urandom));
         2, 3: return enc_r(pick_reg(), pick_reg(), pick_reg(), FUNCT_ADDU);
         4:    return enc_r(pick_reg(), pick_reg(), pick_reg(),
                            ($urandom_range(0, 1) == 0) ? FUNCT_SUB : FUNCT_SUBU);
         5, 6: return enc_i(OP_LW, pick_reg(), pick_reg(), 16'($urandom_range(0, 1023)));
         7, 8: return enc_i(OP_SW, pick_reg(), pick_reg(), 16'($urandom_range(0, 1023)));
         9:    return enc_i(OP_BNE, pick_reg(), pick_reg(), 16'($urandom_range(0, 3)));
         10:   return enc_i(($urandom_range(0, 1) == 0) ? OP_J : OP_BEQ,
                            pick_reg(), pick_reg(), 16'($urandom));
         default: begin
            op = 6'($urandom_range(8, 62));
            return enc_i(op, pick_reg(), pick_reg(), 16'($urandom));
         end
      endcase
   endfunction

   // occasional transaction that does not move the pipeline
   task automatic noise();
      case ($urandom_range(0, 3))
         0: send(ACT_LOAD_DATA, 10'($urandom), 8'($urandom));
         1: send(ACT_READ_REG, 10'($urandom), 8'($urandom));
         2: send(ACT_READ_WORD, 10'($urandom), 8'($urandom));
         default: send(3'($urandom_range(5, 7)), 10'($urandom), 8'($urandom));
      endcase
   endtask

   initial begin
      logic [9:0] at;
      int n, guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, address wrap, unused actions, empty ticks
      send(ACT_LOAD_DATA, 10'd0, 8'hff);
      send(ACT_LOAD_DATA, 10'd1023, 8'h00);
      send(ACT_LOAD_DATA, 10'd1022, 8'h80);
      send(ACT_READ_WORD, 10'd1022, 8'h00);
      send(ACT_READ_WORD, 10'd1023, 8'hff);
      send(ACT_LOAD_INSTR, 10'd1023, 8'h55);
      send(ACT_LOAD_INSTR, 10'd1023, 8'h00);
      send(ACT_READ_REG, 10'd0, 8'h00);
      send(ACT_READ_REG, 10'd1023, 8'h00);
      send(ACT_SPARE_A, 10'd1023, 8'hff);
      send(ACT_SPARE_B, 10'd0, 8'h00);
      send(ACT_SPARE_C, 10'd512, 8'h7f);
      send(ACT_TICK, 10'd0, 8'h00);
      send(ACT_TICK, 10'd1023, 8'hff);

      // directed program: forwarding, wrapped store and load, load-use hold,
      // taken branch, jump and a write to register zero
      at = sb.pc[9:0];
      put_instr(at,           enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7fff));
      put_instr(at + 10'd4,   enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000));
      put_instr(at + 10'd8,   enc_r(5'd1, 5'd2, 5'd3, FUNCT_ADDU));
      put_instr(at + 10'd12,  enc_r(5'd3, 5'd1, 5'd4, FUNCT_SUBU));
      put_instr(at + 10'd16,  enc_i(OP_SW, 5'd0, 5'd3, 16'd1022));
      put_instr(at + 10'd20,  enc_i(OP_LW, 5'd0, 5'd5, 16'd1022));
      put_instr(at + 10'd24,  enc_r(5'd5, 5'd1, 5'd6, FUNCT_ADDU));
      put_instr(at + 10'd28,  enc_i(OP_SW, 5'd0, 5'd5, 16'd4));
      put_instr(at + 10'd32,  enc_i(OP_BNE, 5'd1, 5'd0, 16'd1));
      put_instr(at + 10'd36,  enc_i(OP_ADDI, 5'd0, 5'd7, 16'h1234));
      put_instr(at + 10'd40,  enc_i(OP_J, 5'd0, 5'd0, 16'h0000));
      put_instr(at + 10'd44,  enc_r(5'd1, 5'd1, 5'd0, FUNCT_ADDU));
      repeat (18) send(ACT_TICK, 10'($urandom), 8'($urandom));

      // random blocks: write instructions at the fetch point, then run them
      while (sent < ITEM_TARGET) begin
         n = $urandom_range(1, 5);
         at = sb.pc[9:0];
         for (int i = 0; i < n; i++) put_instr(at + 10'(4 * i), rand_instr());
         repeat (n + $urandom_range(0, 4)) begin
            if ($urandom_range(0, 5) == 0) noise();
            send(ACT_TICK, 10'($urandom), 8'($urandom));
         end
      end

      // halt, drain, then read back every register and some data words
      guard = 0;
      while (!sb.all_idle() && guard < 60) begin
         if (!sb.f_idle) put_instr(sb.pc[9:0], HALT_WORD);
         send(ACT_TICK, 10'd0, 8'h00);
         guard++;
      end
      send(ACT_TICK, 10'd0, 8'h00);
      for (int i = 0; i < 32; i++) send(ACT_READ_REG, 10'(i), 8'h00);
      repeat (8) send(ACT_READ_WORD, 10'($urandom), 8'h00);
      req_valid <= 1'b0;

      while (sb.pending.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d transactions, %0d pipeline ticks, %0d results checked",
               sent, sb.ticks, sb.checked);
      $display("Observed %0d register writes and %0d stores, %0d mismatches",
               sb.reg_writes, sb.stores, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
